[sv/jdcd_pkg.sv]
// ----------------------------------------------------------------------------
// jdcd_pkg: shared types and constants for the Julian day converter
// Holds the fixed-point reciprocals, the biases of the integer forms, the
// small constant tables and the stage payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package jdcd_pkg;

  // Field widths.
  localparam int unsigned TENTHS_W = 31;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned YEAR_W   = 20;

  // Internal widths.
  localparam int unsigned JDAY_W = 28;  // whole Julian day
  localparam int unsigned QUO_W  = 13;  // century count plus bias
  localparam int unsigned NUM_W  = 30;  // numerators of the two wide divides
  localparam int unsigned CYC_W  = 20;  // year count c
  localparam int unsigned REM_W  = 9;   // days left after whole years, b - d
  localparam int unsigned YP_W   = 21;  // year before offset and clamp

  // Exact reciprocals: floor(x / D) == (x * MUL) >> SH for every x in range.
  localparam int unsigned DIV10_SH = 35;
  localparam logic [31:0] DIV10_MUL =
    32'(((64'd1 << DIV10_SH) + 64'd9) / 64'd10);

  localparam int unsigned DIVAB_SH = 48;
  localparam logic [30:0] DIVAB_MUL =
    31'(((64'd1 << DIVAB_SH) + 64'd146096) / 64'd146097);

  localparam int unsigned DIVC_SH = 41;
  localparam logic [30:0] DIVC_MUL =
    31'(((64'd1 << DIVC_SH) + 64'd1460) / 64'd1461);

  // Biases of the integer forms.
  // ab + 52 = floor((4*j + AB_BIAS) / 146097)
  localparam logic [NUM_W-1:0]  AB_BIAS    = 30'd128179;
  // b = j + q - floor(q/4) + B_BIAS, with q = ab + 52
  localparam logic [JDAY_W:0]   B_BIAS     = 29'd1486;
  // c = floor((4*b - C_BIAS) / 1461)
  localparam logic [NUM_W-1:0]  C_BIAS     = 30'd489;
  localparam logic [10:0]       DAYS_4YR   = 11'd1461;
  localparam logic [YP_W-1:0]   YEAR_BASE  = 21'd4716;
  localparam logic [YP_W-1:0]   YEAR_SPLIT = 21'd6616;  // 4716 + 1900

  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [3:0] E_WRAP     = 4'd14;

  // Payload after the rounding and century stages.
  typedef struct packed {
    logic [JDAY_W-1:0] jday;
    logic [QUO_W-1:0]  quo;
  } front_t;

  // Payload after the year stages.
  typedef struct packed {
    logic [CYC_W-1:0] cyc;
    logic [REM_W-1:0] rem_days;
  } mid_t;

  // Smallest b - d at which the month index e reaches k: ceil(30.61 * k).
  function automatic logic [REM_W-1:0] e_threshold(input logic [3:0] k);
    logic [REM_W-1:0] thr;
    unique case (k)
      4'd0:    thr = 9'd0;
      4'd1:    thr = 9'd31;
      4'd2:    thr = 9'd62;
      4'd3:    thr = 9'd92;
      4'd4:    thr = 9'd123;
      4'd5:    thr = 9'd154;
      4'd6:    thr = 9'd184;
      4'd7:    thr = 9'd215;
      4'd8:    thr = 9'd245;
      4'd9:    thr = 9'd276;
      4'd10:   thr = 9'd307;
      4'd11:   thr = 9'd337;
      4'd12:   thr = 9'd368;
      4'd13:   thr = 9'd398;
      4'd14:   thr = 9'd429;
      default: thr = 9'd460;
    endcase
    return thr;
  endfunction

  // Days before month index e: floor(30.61 * e).
  function automatic logic [REM_W-1:0] e_days(input logic [3:0] e);
    logic [REM_W-1:0] days;
    unique case (e)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd30;
      4'd2:    days = 9'd61;
      4'd3:    days = 9'd91;
      4'd4:    days = 9'd122;
      4'd5:    days = 9'd153;
      4'd6:    days = 9'd183;
      4'd7:    days = 9'd214;
      4'd8:    days = 9'd244;
      4'd9:    days = 9'd275;
      4'd10:   days = 9'd306;
      4'd11:   days = 9'd336;
      4'd12:   days = 9'd367;
      4'd13:   days = 9'd397;
      4'd14:   days = 9'd428;
      default: days = 9'd459;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

[sv/jdcd_if.sv]
// ----------------------------------------------------------------------------
// jdcd_if: channel interfaces of the Julian day converter
// One interface for the incoming date word and one for the calendar word,
// each with valid, ready and its payload fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface jdcd_in_if;
  logic                          valid;
  logic                          ready;
  logic [jdcd_pkg::TENTHS_W-1:0] julian_tenths;

  modport source (output valid, output julian_tenths, input ready);
  modport sink   (input valid, input julian_tenths, output ready);
endinterface

interface jdcd_out_if;
  logic                         valid;
  logic                         ready;
  logic [jdcd_pkg::MONTH_W-1:0] month;
  logic [jdcd_pkg::DAY_W-1:0]   day_of_month;
  logic [jdcd_pkg::YEAR_W-1:0]  year_offset;

  modport source (output valid, output month, output day_of_month, output year_offset,
                  input ready);
  modport sink   (input valid, input month, input day_of_month, input year_offset,
                  output ready);
endinterface

`default_nettype wire

[sv/jdcd_front.sv]
// ----------------------------------------------------------------------------
// jdcd_front: rounding and century correction stages
// Three stages: divide by ten, round to the whole day, then the Gregorian
// century count by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module jdcd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [jdcd_pkg::TENTHS_W-1:0] tenths_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output jdcd_pkg::front_t              out_data_o
);
  import jdcd_pkg::*;

  logic [2:0] valid_q;
  logic [2:0] en;

  logic [62:0]       prod10;
  logic [JDAY_W-1:0] whole_d, whole_q;
  logic [3:0]        tlo_q;
  logic [3:0]        tens_lo;
  logic [3:0]        rem;
  logic [JDAY_W-1:0] j2_d, j2_q, j3_q;
  logic [NUM_W-1:0]  x_d, x_q;
  logic [60:0]       prodab;
  logic [QUO_W-1:0]  q_d, q_q;

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    en[2] = !valid_q[2] || out_ready_i;
    en[1] = !valid_q[1] || en[2];
    en[0] = !valid_q[0] || en[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
      if (en[2]) valid_q[2] <= valid_q[1];
    end
  end

  // Stage 1: whole days.
  assign prod10  = 63'(tenths_i) * 63'(DIV10_MUL);
  assign whole_d = prod10[DIV10_SH +: JDAY_W];

  // Stage 2: the tenths digit is the low nibble of t - 10 * whole.
  assign tens_lo = {whole_q[2:0], 1'b0} + {whole_q[0], 3'b000};
  assign rem     = tlo_q - tens_lo;
  assign j2_d    = whole_q + JDAY_W'(rem >= 4'd5);
  assign x_d     = {j2_d, 2'b00} + AB_BIAS;

  // Stage 3: biased century count.
  assign prodab = 61'(x_q) * 61'(DIVAB_MUL);
  assign q_d    = prodab[DIVAB_SH +: QUO_W];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      whole_q <= whole_d;
      tlo_q   <= tenths_i[3:0];
    end
    if (en[1]) begin
      j2_q <= j2_d;
      x_q  <= x_d;
    end
    if (en[2]) begin
      j3_q <= j2_q;
      q_q  <= q_d;
    end
  end

  assign in_ready_o       = en[0];
  assign out_valid_o      = valid_q[2];
  assign out_data_o.jday  = j3_q;
  assign out_data_o.quo   = q_q;

endmodule

`default_nettype wire

[sv/jdcd_mid.sv]
// ----------------------------------------------------------------------------
// jdcd_mid: year count stages
// Three stages: the shifted day count b, the year count c by reciprocal
// multiplication, and the days left in the year, b - d.
// ----------------------------------------------------------------------------
`default_nettype none

module jdcd_mid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  jdcd_pkg::front_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output jdcd_pkg::mid_t   out_data_o
);
  import jdcd_pkg::*;

  logic [2:0] valid_q;
  logic [2:0] en;

  logic [JDAY_W-1:0] b_d;
  logic [REM_W-1:0]  blo4_q, blo5_q;
  logic [NUM_W-1:0]  y_d, y_q;
  logic [60:0]       prodc;
  logic [CYC_W-1:0]  c_d, c5_q, c6_q;
  logic [10:0]       d_prod;
  logic [REM_W-1:0]  bd_d, bd_q;

  always_comb begin
    en[2] = !valid_q[2] || out_ready_i;
    en[1] = !valid_q[1] || en[2];
    en[0] = !valid_q[0] || en[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
      if (en[2]) valid_q[2] <= valid_q[1];
    end
  end

  // Stage 4: b never goes negative, so all of this stays unsigned.
  assign b_d = JDAY_W'(29'(in_data_i.jday) + 29'(in_data_i.quo)
                       - 29'(in_data_i.quo >> 2) + B_BIAS);
  assign y_d = {b_d, 2'b00} - C_BIAS;

  // Stage 5: year count.
  assign prodc = 61'(y_q) * 61'(DIVC_MUL);
  assign c_d   = prodc[DIVC_SH +: CYC_W];

  // Stage 6: b - d lies in 123..488, so only the low bits of both are needed.
  assign d_prod = c5_q[10:0] * DAYS_4YR;
  assign bd_d   = blo5_q - d_prod[10:2];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      blo4_q <= b_d[REM_W-1:0];
      y_q    <= y_d;
    end
    if (en[1]) begin
      blo5_q <= blo4_q;
      c5_q   <= c_d;
    end
    if (en[2]) begin
      c6_q <= c5_q;
      bd_q <= bd_d;
    end
  end

  assign in_ready_o          = en[0];
  assign out_valid_o         = valid_q[2];
  assign out_data_o.cyc      = c6_q;
  assign out_data_o.rem_days = bd_q;

endmodule

`default_nettype wire

[sv/jdcd_back.sv]
// ----------------------------------------------------------------------------
// jdcd_back: month, day and year stages
// Finds the month index by a threshold search, then forms month, day and
// the offset year into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jdcd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  jdcd_pkg::mid_t               in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [jdcd_pkg::MONTH_W-1:0] month_o,
  output logic [jdcd_pkg::DAY_W-1:0]   day_o,
  output logic [jdcd_pkg::YEAR_W-1:0]  year_o
);
  import jdcd_pkg::*;

  logic [1:0] valid_q;
  logic [1:0] en;

  logic [3:0]         e_d, e_q;
  logic [REM_W-1:0]   bd_q;
  logic [CYC_W-1:0]   c_q;
  logic [MONTH_W-1:0] month_d, month_q;
  logic [DAY_W-1:0]   day_d, day_q;
  logic [YP_W-1:0]    yp;
  logic [YEAR_W-1:0]  year_d, year_q;

  always_comb begin
    en[1] = !valid_q[1] || out_ready_i;
    en[0] = !valid_q[0] || en[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
    end
  end

  // Stage 7: e is the largest k whose threshold b - d reaches.
  always_comb begin
    e_d = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (in_data_i.rem_days >= e_threshold(4'(k))) e_d = 4'(k);
    end
  end

  // Stage 8: March-based month index back to January-based month, then the day and the offset year.
  always_comb begin
    month_d = (e_q >= E_WRAP) ? e_q - 4'd13 : e_q - 4'd1;
    day_d   = DAY_W'(bd_q - e_days(e_q));
    yp      = YP_W'(c_q) + YP_W'(month_d <= MONTH_FEB);
    priority if (yp > YEAR_SPLIT) begin
      year_d = YEAR_W'(yp - YEAR_SPLIT);
    end else if (yp >= YEAR_BASE) begin
      year_d = YEAR_W'(yp - YEAR_BASE);
    end else begin
      year_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      e_q  <= e_d;
      bd_q <= in_data_i.rem_days;
      c_q  <= in_data_i.cyc;
    end
    if (en[1]) begin
      month_q <= month_d;
      day_q   <= day_d;
      year_q  <= year_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[1];
  assign month_o     = month_q;
  assign day_o       = day_q;
  assign year_o      = year_q;

endmodule

`default_nettype wire

[sv/julian_day_to_calendar_date_unit.sv]
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date_unit: Julian day to Gregorian calendar date
// Converts a Julian date in tenths of a day to month, day of month and a
// year offset, in an eight-stage pipeline.
// ----------------------------------------------------------------------------
//
//   Port    Direction  Word contents
//   ------  ---------  -------------------------------------------------
//   in_i    sink       julian_tenths (31 b): Julian date times ten
//   out_o   source     month (4 b), day_of_month (5 b), year_offset (20 b)
//
// A word passes through the front, middle and back stages in order, and the
// last back stage is the output register. While the sink does not stall, a
// new word can be accepted in every cycle, so the rate is one word per clock.
// The two wide reciprocal multiplies (by 1/146097 and by 1/1461) and the
// divide by ten each fill one stage and set the clock period.
// Reset clears only the stage valid bits; the data registers are not reset.
// When the output is held, each stage still takes a word if it is empty, so
// bubbles close up and no word is dropped or repeated.
//
`default_nettype none

module julian_day_to_calendar_date_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  jdcd_in_if.sink    in_i,
  jdcd_out_if.source out_o
);
  import jdcd_pkg::*;

  // Section boundaries between the front, middle and back stages.
  logic   front_valid;
  logic   front_ready;
  front_t front_data;
  logic   mid_valid;
  logic   mid_ready;
  mid_t   mid_data;

  // Divide by ten, round to the whole day, and count Gregorian centuries.
  jdcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .tenths_i    (in_i.julian_tenths),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_data_o  (front_data)
  );

  // Count whole years from the March-based epoch and the days left over.
  jdcd_mid u_mid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_data_i   (front_data),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_data_o  (mid_data)
  );

  // Split the leftover days into month and day, and offset the year.
  jdcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_data_i   (mid_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .month_o     (out_o.month),
    .day_o       (out_o.day_of_month),
    .year_o      (out_o.year_offset)
  );

endmodule

`default_nettype wire

[sv/jdcd_checker.sv]
// ----------------------------------------------------------------------------
// jdcd_checker: port-level checks of the Julian day converter
// Watches the two channels and checks stall behavior and result ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module jdcd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [jdcd_pkg::MONTH_W-1:0] month_i,
  input logic [jdcd_pkg::DAY_W-1:0]   day_i,
  input logic [jdcd_pkg::YEAR_W-1:0]  year_i
);
  import jdcd_pkg::*;

  // A held result word stays in place until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(month_i) && $stable(day_i) && $stable(year_i))
    else $error("result word changed while stalled");

  // With the output free to move, every stage moves and the input is open.
  a_ready_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input blocked while output can drain");

  // The wrap of month indices 14 and 15 always lands in January..December.
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (month_i >= 4'd1) && (month_i <= 4'd12))
    else $error("month out of range");

  // The day is at least one because the month threshold is a ceiling.
  a_day_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> day_i != '0)
    else $error("day of month is zero");

endmodule

bind julian_day_to_calendar_date_unit jdcd_checker u_jdcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .month_i     (out_o.month),
  .day_i       (out_o.day_of_month),
  .year_i      (out_o.year_offset)
);

`default_nettype wire

[sim/julian_date_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julian_date_checker: calendar date scoreboard for the Julian day converter
// Watches the date and calendar channels. It converts every accepted date
// word into the expected calendar word and compares the results in order.
// ----------------------------------------------------------------------------

module julian_date_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  jdcd_in_if          date_mon_i,
  jdcd_out_if         cal_mon_i,
  output int unsigned mismatches_o,
  output int unsigned words_in_flight_o
);
  import jdcd_pkg::*;

  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
    logic [YEAR_W-1:0]  year_offset;
  } cal_date_t;

  localparam longint CENT_SCALE  = 64'sd400000;
  localparam longint CENT_OFFSET = 64'sd5112264 * 64'sd146097;
  localparam longint CENT_DIV    = 64'sd14609700000;
  localparam longint YEAR_SCALE  = 64'sd40000;
  localparam longint YEAR_OFFSET = 64'sd3343 * 64'sd1461;
  localparam longint YEAR_DIV    = 64'sd14610000;

  cal_date_t   expected_dates[$];
  int unsigned mismatch_count = 0;
  int unsigned in_flight      = 0;

  assign mismatches_o      = mismatch_count;
  assign words_in_flight_o = in_flight;

  // Division that rounds toward minus infinity; the divisor is always positive.
  function automatic longint floor_quot(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic cal_date_t gregorian_from_tenths(input logic [TENTHS_W-1:0] tenths);
    longint    raw;
    longint    jd;
    longint    cent;
    longint    shifted;
    longint    yrs;
    longint    yr_days;
    longint    mon_idx;
    longint    dom;
    longint    mon;
    longint    yr;
    cal_date_t res;
    raw = longint'(tenths);
    jd  = raw / 10;
    if ((raw % 10) >= 5) jd = jd + 1;
    // The Gregorian century correction is applied at every date.
    cent    = floor_quot(CENT_SCALE * jd - CENT_OFFSET, CENT_DIV);
    shifted = jd + 1 + cent - floor_quot(cent, 4) + 1524;
    yrs     = floor_quot(YEAR_SCALE * shifted - YEAR_OFFSET, YEAR_DIV);
    yr_days = floor_quot(1461 * yrs, 4);
    mon_idx = floor_quot(100 * (shifted - yr_days), 3061);
    dom     = shifted - yr_days - floor_quot(3061 * mon_idx, 100);
    mon     = mon_idx - 1;
    yr      = yrs - 4716;
    if (mon_idx >= 14) mon = mon - 12;
    if (mon <= 2) yr = yr + 1;
    if (yr > 1900) yr = yr - 1900;
    if (yr < 0) yr = 0;
    res.month        = mon[MONTH_W-1:0];
    res.day_of_month = dom[DAY_W-1:0];
    res.year_offset  = yr[YEAR_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count = mismatch_count + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cal_date_t want;
    if (!rst_ni) begin
      expected_dates.delete();
      in_flight = 0;
    end else begin
      if (date_mon_i.valid && date_mon_i.ready) begin
        expected_dates.push_back(gregorian_from_tenths(date_mon_i.julian_tenths));
      end
      if (cal_mon_i.valid && cal_mon_i.ready) begin
        if (expected_dates.size() == 0) begin
          report_mismatch($sformatf("unexpected word month=%0d day=%0d year=%0d",
                                    cal_mon_i.month, cal_mon_i.day_of_month,
                                    cal_mon_i.year_offset));
        end else begin
          want = expected_dates.pop_front();
          if (cal_mon_i.month !== want.month)
            report_mismatch($sformatf("month got %0d want %0d",
                                      cal_mon_i.month, want.month));
          if (cal_mon_i.day_of_month !== want.day_of_month)
            report_mismatch($sformatf("day_of_month got %0d want %0d",
                                      cal_mon_i.day_of_month, want.day_of_month));
          if (cal_mon_i.year_offset !== want.year_offset)
            report_mismatch($sformatf("year_offset got %0d want %0d",
                                      cal_mon_i.year_offset, want.year_offset));
        end
      end
      in_flight = expected_dates.size();
    end
  end

endmodule

[sim/tb_julian_day_to_calendar_date_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_julian_day_to_calendar_date_unit: testbench of the Julian day converter
// Sends directed and random Julian dates through the converter under four
// flow-control patterns while a checker compares each calendar word with
// its own calculation of the expected month, day and year offset.
// ----------------------------------------------------------------------------

module tb_julian_day_to_calendar_date_unit;
  import jdcd_pkg::*;

  // Flow-control patterns. Each random phase runs under one of them.
  typedef enum logic [1:0] {
    FLOW_STEADY,       // neither side ever idles
    FLOW_SLOW_SOURCE,  // the date source idles with a chance of 70 percent
    FLOW_SLOW_SINK,    // the calendar sink stalls with a chance of 70 percent
    FLOW_LIGHT_BOTH    // both sides idle with a chance of 7 percent
  } flow_e;

  localparam int unsigned WORDS_PER_PHASE = 475;
  // The pipeline is eight stages deep; give it a good margin after draining.
  localparam int unsigned DRAIN_CYCLES    = 24;

  logic        clk_i;
  logic        rst_ni;
  flow_e       flow;
  int unsigned mismatches;
  int unsigned words_in_flight;

  jdcd_in_if  date_if ();
  jdcd_out_if cal_if ();

  julian_day_to_calendar_date_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (date_if),
    .out_o  (cal_if)
  );

  julian_date_checker date_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .date_mon_i        (date_if),
    .cal_mon_i         (cal_if),
    .mismatches_o      (mismatches),
    .words_in_flight_o (words_in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the converter hangs and the words never drain.
  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic bit source_rests();
    case (flow)
      FLOW_SLOW_SOURCE: return $urandom_range(99) < 70;
      FLOW_LIGHT_BOTH:  return $urandom_range(99) < 7;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic bit sink_stalls();
    case (flow)
      FLOW_SLOW_SINK:  return $urandom_range(99) < 70;
      FLOW_LIGHT_BOTH: return $urandom_range(99) < 7;
      default:         return 1'b0;
    endcase
  endfunction

  // The calendar sink: ready is redrawn at every rising edge.
  initial begin
    cal_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cal_if.ready <= !sink_stalls();
    end
  end

  // Presents one date word and returns just after the edge that accepted it.
  // All signals change only around the rising edge, so ready is settled at
  // the falling edge and holds the value that the next rising edge will see.
  task automatic send_date(input logic [TENTHS_W-1:0] tenths);
    bit taken;
    while (source_rests()) begin
      date_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    date_if.valid         <= 1'b1;
    date_if.julian_tenths <= tenths;
    do begin
      @(negedge clk_i);
      taken = date_if.ready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Holds the source quiet until every word already sent has come back.
  task automatic wait_until_drained();
    date_if.valid <= 1'b0;
    do @(negedge clk_i); while (words_in_flight != 0);
    @(posedge clk_i);
  endtask

  // Random dates: a mix of the whole input range (every bit toggles), the
  // historical range where the calendar is in use, and dates whose tenths
  // digit sits right at the rounding threshold.
  function automatic logic [TENTHS_W-1:0] random_date();
    int unsigned pick;
    logic [TENTHS_W-1:0] d;
    pick = $urandom_range(99);
    if (pick < 40) begin
      d = TENTHS_W'($urandom);
    end else if (pick < 75) begin
      d = TENTHS_W'($urandom_range(30000000));
    end else begin
      d = TENTHS_W'($urandom_range(26000000, 17000000));
      d = d - (d % 10) + TENTHS_W'($urandom_range(5, 4));
    end
    return d;
  endfunction

  logic [TENTHS_W-1:0] directed_dates[$] = '{
    31'd0, 31'd4, 31'd5, 31'd9,              // day zero, rounding, year clamps to 0
    31'h7FFF_FFFF, 31'd2147483644,           // the largest inputs
    31'h2AAA_AAAA, 31'h5555_5555,            // alternating bit patterns
    31'd17210550, 31'd17210600,              // around the year zero crossing
    31'd17214260,                            // early first-century date
    31'd22991600, 31'd22991610,              // either side of the calendar reform
    31'd24150210, 31'd24153850, 31'd24153860,// 1900 and the first day above it
    31'd24515444, 31'd24515449, 31'd24515450,// tenths digit 4, 9, 0 and 5, either side of 5
    31'd24515455,
    31'd24516040, 31'd24516050               // leap day and the day after
  };

  initial begin
    date_if.valid         <= 1'b0;
    date_if.julian_tenths <= '0;
    flow                   = FLOW_STEADY;
    rst_ni                 = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words first, with neither side idling.
    foreach (directed_dates[i]) send_date(directed_dates[i]);
    wait_until_drained();

    // Random words under each flow-control pattern. Halfway through each
    // phase the source stops until the pipeline has emptied, so that the
    // converter also restarts from an empty state under every pattern.
    for (int p = 0; p < 4; p++) begin
      flow = flow_e'(p);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n == WORDS_PER_PHASE / 2) wait_until_drained();
        send_date(random_date());
      end
    end

    // Let everything come back, then allow for any stray late words.
    date_if.valid <= 1'b0;
    flow           = FLOW_STEADY;
    do @(negedge clk_i); while (words_in_flight != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && words_in_flight == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
